[hw/rtl/slc_pkg.sv]
package slc_pkg;

    // Default sizing of the model stores
    localparam int MAX_CLASSES_DEF  = 8;
    localparam int MAX_FEATURES_DEF = 1024;

    // Width of the effective class count, enough for the largest class range
    localparam int NC_W = 5;

    // Depth of the command queue between front and back (power of two)
    localparam int Q_DEPTH = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT = 1'b1;

    localparam logic [3:0]  CLASS_COUNT_RST   = 4'd2;
    localparam logic [10:0] FEATURE_COUNT_RST = 11'd1024;

    // Request codes, also used as command codes on the queue
    localparam logic [1:0] REQ_FEATURE = 2'd0;
    localparam logic [1:0] REQ_WEIGHT  = 2'd1;
    localparam logic [1:0] REQ_LABEL   = 2'd2;

    // Input beat
    typedef struct packed {
        logic [1:0]         req_type;
        logic [10:0]        feature_index;
        logic signed [31:0] feature_value;
        logic               is_last;
        logic [2:0]         class_index;
        logic signed [31:0] weight_value;
        logic signed [31:0] label_value;
    } t_req;

    // Result beat
    typedef struct packed {
        logic signed [31:0] predicted_label;
        logic [2:0]         predicted_class;
        logic signed [63:0] decision_score;
    } t_res;

    // Decoded command from front to back
    typedef struct packed {
        logic [1:0]  op;
        logic        add_en;
        logic        is_last;
        logic [10:0] index;
        logic [2:0]  cls;
        logic [31:0] data;
    } t_cmd;

    // Operating mode derived from configuration
    typedef struct packed {
        logic            binary;
        logic [NC_W-1:0] n_classes;
    } t_mode;

endpackage

[hw/rtl/slc_front.sv]
module slc_front #(
    parameter int MAX_CLASSES  = slc_pkg::MAX_CLASSES_DEF,
    parameter int MAX_FEATURES = slc_pkg::MAX_FEATURES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [slc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [slc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    input  slc_pkg::t_req                    i_in_data,
    output logic                             o_in_ready,
    input  logic                             i_q_ready,
    output logic                             o_q_push,
    output slc_pkg::t_cmd                    o_q_cmd,
    output slc_pkg::t_mode                   o_mode
);
    import slc_pkg::*;

    logic [3:0]  r_class_count;
    logic [10:0] r_feature_count;

    logic [31:0] fidx32;
    logic [31:0] cls32;
    logic [31:0] cc32;
    logic [31:0] nc32;
    logic        idx_ok;
    logic        cls_ok;
    logic        keep;

    // Hold the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_count   <= CLASS_COUNT_RST;
            r_feature_count <= FEATURE_COUNT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CLASS_COUNT:   r_class_count   <= i_cfg_data[3:0];
                CFG_FEATURE_COUNT: r_feature_count <= i_cfg_data[10:0];
            endcase
        end
    end

    // Clamp the class count into the supported range
    always_comb begin
        cc32 = 32'(r_class_count);
        if (cc32 < 32'd2) begin
            nc32 = 32'd2;
        end else if (cc32 > 32'(MAX_CLASSES)) begin
            nc32 = 32'(MAX_CLASSES);
        end else begin
            nc32 = cc32;
        end
        o_mode.n_classes = NC_W'(nc32);
        o_mode.binary    = (nc32 == 32'd2);
    end

    // Classify the beat: decide whether it reaches the back end at all
    assign fidx32 = 32'(i_in_data.feature_index);
    assign cls32  = 32'(i_in_data.class_index);
    assign idx_ok = (fidx32 >= 32'd1) && (fidx32 <= 32'(MAX_FEATURES));
    assign cls_ok = cls32 < 32'(MAX_CLASSES);

    always_comb begin
        o_q_cmd.op      = i_in_data.req_type;
        o_q_cmd.is_last = i_in_data.is_last;
        o_q_cmd.index   = i_in_data.feature_index;
        o_q_cmd.cls     = i_in_data.class_index;
        o_q_cmd.add_en  = 1'b0;
        o_q_cmd.data    = i_in_data.feature_value;
        unique case (i_in_data.req_type)
            REQ_FEATURE: begin
                keep           = 1'b1;
                o_q_cmd.add_en = idx_ok && (i_in_data.feature_index <= r_feature_count);
            end
            REQ_WEIGHT: begin
                keep         = idx_ok && cls_ok;
                o_q_cmd.data = i_in_data.weight_value;
            end
            REQ_LABEL: begin
                keep         = cls_ok;
                o_q_cmd.data = i_in_data.label_value;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // Accept whenever the queue has room; drop beats that do nothing
    assign o_in_ready = i_q_ready;
    assign o_q_push   = i_in_valid && i_q_ready && keep;

endmodule

[hw/rtl/slc_queue.sv]
module slc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  slc_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output slc_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import slc_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);

    t_cmd          r_buf [Q_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_ready = (r_cnt != (PW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_buf[r_rp];

    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Store the incoming beat
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wp] <= i_cmd;
        end
    end

    // Advance pointers; they wrap naturally as the depth is a power of two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end

endmodule

[hw/rtl/slc_back.sv]
module slc_back #(
    parameter int MAX_CLASSES  = slc_pkg::MAX_CLASSES_DEF,
    parameter int MAX_FEATURES = slc_pkg::MAX_FEATURES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  slc_pkg::t_mode i_mode,
    input  logic           i_q_valid,
    input  slc_pkg::t_cmd  i_q_cmd,
    output logic           o_q_pop,
    output logic           o_out_valid,
    output slc_pkg::t_res  o_out_data,
    input  logic           i_out_ready
);
    import slc_pkg::*;

    localparam int AW    = $clog2(MAX_FEATURES);
    localparam int CW    = $clog2(MAX_CLASSES);
    localparam int NLEAF = 1 << CW;
    localparam int LV    = CW;

    localparam logic signed [63:0] SCORE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SCORE_MIN = 64'sh8000_0000_0000_0000;

    function automatic logic signed [63:0] sat_add(
        input logic signed [63:0] a,
        input logic signed [63:0] b
    );
        logic signed [63:0] s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63])) begin
            sat_add = a[63] ? SCORE_MIN : SCORE_MAX;
        end else begin
            sat_add = s;
        end
    endfunction

    // Pipeline control
    logic          adv;
    logic          last_in_flight;
    logic          lbl_hold;
    logic          pop_feat;
    logic          pop_rd;
    logic [31:0]   idx_m1;
    logic [AW-1:0] addr;
    logic [CW-1:0] lbl_addr;
    logic [NC_W:0] nw;

    // Stage registers
    logic               r_s1_v;
    logic               r_s1_add;
    logic               r_s1_last;
    logic signed [31:0] r_s1_val;
    logic               r_s2_v;
    logic               r_s2_add;
    logic               r_s2_last;

    logic signed [31:0] r_rd    [MAX_CLASSES];
    logic signed [63:0] r_prod  [MAX_CLASSES];
    logic signed [63:0] r_score [MAX_CLASSES];
    logic signed [63:0] sum     [MAX_CLASSES];
    logic signed [31:0] r_lbl   [MAX_CLASSES];

    // Comparison tree, heap order: node n takes children 2n and 2n+1
    logic signed [63:0] r_tsc [1:2*NLEAF-1];
    logic [CW-1:0]      r_tix [1:2*NLEAF-1];
    logic               r_tok [1:2*NLEAF-1];
    logic [LV:0]        r_tv;

    logic          r_out_valid;
    t_res          r_out_data;
    logic [CW-1:0] win;

    assign adv = !r_out_valid || i_out_ready;

    // Hold label writes while a result that still reads the label table is in flight
    assign last_in_flight = (r_s1_v && r_s1_last) || (r_s2_v && r_s2_last) || (|r_tv);
    assign lbl_hold       = (i_q_cmd.op == REQ_LABEL) && last_in_flight;
    assign o_q_pop        = i_q_valid && adv && !lbl_hold;
    assign pop_feat       = o_q_pop && (i_q_cmd.op == REQ_FEATURE);
    assign pop_rd         = pop_feat && i_q_cmd.add_en;

    assign idx_m1   = 32'(i_q_cmd.index) - 32'd1;
    assign addr     = idx_m1[AW-1:0];
    assign lbl_addr = CW'(i_q_cmd.cls);
    assign nw       = i_mode.binary ? (NC_W+1)'(1) : (NC_W+1)'(i_mode.n_classes);

    // Stage 1 control: beat popped, weight row being read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (adv) begin
            r_s1_v <= pop_feat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_add  <= i_q_cmd.add_en;
            r_s1_last <= i_q_cmd.is_last;
            r_s1_val  <= i_q_cmd.data;
        end
    end

    // Stage 2 control: products formed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (adv) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_add  <= r_s1_add;
            r_s2_last <= r_s1_last;
        end
    end

    // Write the class label table
    always_ff @(posedge i_clk) begin
        if (o_q_pop && (i_q_cmd.op == REQ_LABEL)) begin
            r_lbl[lbl_addr] <= i_q_cmd.data;
        end
    end

    // One lane per class: weight memory, multiplier and accumulator
    for (genvar l = 0; l < MAX_CLASSES; l++) begin : g_lane
        logic signed [31:0] r_wmem [MAX_FEATURES];
        logic               wr_en;
        logic               lane_on;

        assign wr_en   = o_q_pop && (i_q_cmd.op == REQ_WEIGHT) &&
                         (32'(i_q_cmd.cls) == 32'(l));
        assign lane_on = 32'(l) < 32'(nw);

        // Write the weight memory
        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                r_wmem[addr] <= i_q_cmd.data;
            end
        end

        // Read one weight row entry per element
        always_ff @(posedge i_clk) begin
            if (adv && pop_rd) begin
                r_rd[l] <= r_wmem[addr];
            end
        end

        // Multiply weight by feature value
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_prod[l] <= r_rd[l] * r_s1_val;
            end
        end

        assign sum[l] = (r_s2_add && lane_on) ? sat_add(r_score[l], r_prod[l]) : r_score[l];

        // Accumulate; clear after the last element of a vector
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_score[l] <= '0;
            end else if (adv && r_s2_v) begin
                if (r_s2_last) begin
                    r_score[l] <= '0;
                end else begin
                    r_score[l] <= sum[l];
                end
            end
        end
    end

    // Load the tree leaves with final scores
    for (genvar l = 0; l < NLEAF; l++) begin : g_leaf
        if (l < MAX_CLASSES) begin : g_real
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_tsc[NLEAF+l] <= sum[l];
                    r_tix[NLEAF+l] <= CW'(l);
                    r_tok[NLEAF+l] <= (32'(l) < 32'(nw));
                end
            end
        end else begin : g_pad
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_tsc[NLEAF+l] <= '0;
                    r_tix[NLEAF+l] <= CW'(l);
                    r_tok[NLEAF+l] <= 1'b0;
                end
            end
        end
    end

    // Reduce pairwise; the left child keeps ties so the first maximum wins
    for (genvar n = 1; n < NLEAF; n++) begin : g_node
        logic pick_r;
        assign pick_r = r_tok[2*n+1] && (!r_tok[2*n] || (r_tsc[2*n+1] > r_tsc[2*n]));

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_tsc[n] <= pick_r ? r_tsc[2*n+1] : r_tsc[2*n];
                r_tix[n] <= pick_r ? r_tix[2*n+1] : r_tix[2*n];
                r_tok[n] <= r_tok[2*n] || r_tok[2*n+1];
            end
        end
    end

    // Track which tree level carries a finished vector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= '0;
        end else if (adv) begin
            r_tv <= {r_tv[LV-1:0], r_s2_v && r_s2_last};
        end
    end

    // Pick the winner; the binary case decides on the sign of class 0
    always_comb begin
        if (i_mode.binary) begin
            win = (r_tsc[1] > 64'sd0) ? CW'(0) : CW'(1);
        end else begin
            win = r_tix[1];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_tv[LV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_tv[LV]) begin
            r_out_data.predicted_label <= r_lbl[win];
            r_out_data.predicted_class <= 3'(win);
            r_out_data.decision_score  <= r_tsc[1];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[hw/rtl/sparse_linear_classifier_core.sv]
// Path: a last feature element gives its result after weight read, multiply,
// accumulate, comparison tree and output, in that order.
// Throughput: one beat per cycle while the command queue has room; a label write
// behind a last element waits until that result enters the output register.
// Reset: synchronous, active low; clears control, scores and configuration.
// Weight memories and the label table are not cleared and must be written before use.
module sparse_linear_classifier_core #(
    parameter int MAX_CLASSES  = slc_pkg::MAX_CLASSES_DEF,
    parameter int MAX_FEATURES = slc_pkg::MAX_FEATURES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [slc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [slc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  slc_pkg::t_req                  i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output slc_pkg::t_res                  o_out_data
);
    import slc_pkg::*;

    logic  q_ready;
    logic  q_push;
    t_cmd  q_in;
    logic  q_valid;
    t_cmd  q_out;
    logic  q_pop;
    t_mode mode;

    // Configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    slc_front #(
        .MAX_CLASSES (MAX_CLASSES),
        .MAX_FEATURES(MAX_FEATURES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .i_q_ready  (q_ready),
        .o_q_push   (q_push),
        .o_q_cmd    (q_in),
        .o_mode     (mode)
    );

    slc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (q_in),
        .o_ready(q_ready),
        .o_valid(q_valid),
        .o_cmd  (q_out),
        .i_pop  (q_pop)
    );

    slc_back #(
        .MAX_CLASSES (MAX_CLASSES),
        .MAX_FEATURES(MAX_FEATURES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (mode),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_out),
        .o_q_pop    (q_pop),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_ready(i_out_ready)
    );

endmodule

[hw/rtl/slc_checker.sv]
module slc_checker #(
    parameter int MAX_CLASSES = slc_pkg::MAX_CLASSES_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [slc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [slc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input slc_pkg::t_res                  o_out_data
);
    import slc_pkg::*;

    logic [3:0] r_cc;
    logic       bin_mode;

    // Shadow the class count to know when the block runs binary
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc <= CLASS_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready && (i_cfg_index == CFG_CLASS_COUNT)) begin
            r_cc <= i_cfg_data[3:0];
        end
    end

    assign bin_mode = (r_cc <= 4'd2) || (MAX_CLASSES == 2);

    // No result beat straight out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat shown after reset");

    // A stalled result beat stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // Binary decision follows the sign of the reported score
    a_bin_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && bin_mode |->
        ((o_out_data.predicted_class == 3'd0) == (o_out_data.decision_score > 64'sd0)))
        else $error("binary class does not match score sign");

endmodule

bind sparse_linear_classifier_core slc_checker #(.MAX_CLASSES(MAX_CLASSES)) u_chk (.*);

[test/testbench.sv]
module testbench;
    import slc_pkg::*;

    localparam int NUM_CLS         = MAX_CLASSES_DEF;
    localparam int NUM_FEAT        = MAX_FEATURES_DEF;
    localparam int RESULT_LATENCY  = 7;
    localparam int SETTLE_CYCLES   = 3 * RESULT_LATENCY;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RAND_PER_PHASE  = 75;
    localparam int SQUEEZE_BEATS   = 24;

    // Request code the block does not know
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Per-phase class count, feature count and idling
    localparam int PHASES      = 9;
    localparam int HOLD_PHASE  = 4;
    localparam int PAUSE_PHASE = 5;
    localparam int PH_CC [PHASES]         = '{8, 2034, 15, 3, 1, 5, 0, 8, 7};
    localparam int PH_FC [PHASES]         = '{1024, 2047, 1, 0, 1025, 300, 512, 1024, 1000};
    localparam int PH_SEND_IDLE [PHASES]  = '{0, 64, 0, 23, 0, 64, 0, 23, 0};
    localparam int PH_RECV_STALL [PHASES] = '{0, 0, 64, 23, 0, 0, 64, 23, 0};

    // Scores every accepted request beat and holds the labels still owed
    class label_predictor;
        logic signed [31:0] weight_mem [NUM_CLS*NUM_FEAT];
        logic signed [31:0] label_tab [NUM_CLS];
        logic signed [63:0] acc [NUM_CLS];
        logic [3:0]         class_count_q;
        logic [10:0]        feature_count_q;
        t_res               predicted_q [$];
        int unsigned        mismatch_cnt;

        function new();
            class_count_q   = CLASS_COUNT_RST;
            feature_count_q = FEATURE_COUNT_RST;
            foreach (acc[c]) acc[c] = '0;
            mismatch_cnt = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_CLASS_COUNT)
                class_count_q = data[3:0];
            else if (idx == CFG_FEATURE_COUNT)
                feature_count_q = data[10:0];
        endfunction

        // Add with saturation to the signed 64-bit range
        function logic signed [63:0] clamp_sum(logic signed [63:0] a, logic signed [63:0] b);
            logic [64:0] s;
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63])
                return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            return s[63:0];
        endfunction

        function void take_request(t_req r);
            int unsigned        n_cls, n_acc, n_feat, win, c;
            logic signed [63:0] wx, vx, best;
            t_res               res;
            n_cls  = (class_count_q < 2) ? 2 :
                     (class_count_q > NUM_CLS) ? NUM_CLS : class_count_q;
            n_acc  = (n_cls == 2) ? 1 : n_cls;
            n_feat = (feature_count_q > NUM_FEAT) ? NUM_FEAT : feature_count_q;
            case (r.req_type)
                REQ_WEIGHT: begin
                    if (r.feature_index >= 1 && r.feature_index <= NUM_FEAT)
                        weight_mem[int'(r.class_index) * NUM_FEAT + int'(r.feature_index) - 1]
                            = r.weight_value;
                end
                REQ_LABEL: begin
                    label_tab[r.class_index] = r.label_value;
                end
                REQ_FEATURE: begin
                    // accumulate weight times value into each live score
                    if (r.feature_index >= 1 && r.feature_index <= n_feat) begin
                        vx = {{32{r.feature_value[31]}}, r.feature_value};
                        for (c = 0; c < n_acc; c++) begin
                            wx = weight_mem[c * NUM_FEAT + int'(r.feature_index) - 1];
                            acc[c] = clamp_sum(acc[c], wx * vx);
                        end
                    end
                    // pick the winner on the closing element, then clear
                    if (r.is_last) begin
                        if (n_cls == 2) begin
                            best = acc[0];
                            win  = (best > 0) ? 0 : 1;
                        end else begin
                            win = 0;
                            for (c = 1; c < n_cls; c++)
                                if (acc[c] > acc[win])
                                    win = c;
                            best = acc[win];
                        end
                        res.predicted_label = label_tab[win];
                        res.predicted_class = 3'(win);
                        res.decision_score  = best;
                        predicted_q.push_back(res);
                        foreach (acc[i]) acc[i] = '0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void log_mismatch(string msg);
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("%s", msg);
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (predicted_q.size() == 0) begin
                log_mismatch($sformatf("result with none expected: label %0d class %0d score %0d",
                    $signed(got.predicted_label), got.predicted_class,
                    $signed(got.decision_score)));
                return;
            end
            want = predicted_q.pop_front();
            if (got.predicted_label !== want.predicted_label)
                log_mismatch($sformatf("predicted_label: expected %0d, got %0d",
                    $signed(want.predicted_label), $signed(got.predicted_label)));
            if (got.predicted_class !== want.predicted_class)
                log_mismatch($sformatf("predicted_class: expected %0d, got %0d",
                    want.predicted_class, got.predicted_class));
            if (got.decision_score !== want.decision_score)
                log_mismatch($sformatf("decision_score: expected %0d, got %0d",
                    $signed(want.decision_score), $signed(got.decision_score)));
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    t_req                  req_data  = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    t_res                  res_data;

    label_predictor sb;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_off_req   = 1'b0;
    int unsigned useful_beats   = 0;
    int unsigned quiet_cycles   = 0;

    // Weight entries written so far, and rows written for every class
    bit          wt_seen [NUM_CLS*NUM_FEAT];
    bit          row_listed [NUM_FEAT+1];
    int unsigned full_rows [$];

    sparse_linear_classifier_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (req_valid),
        .o_in_ready  (req_ready),
        .i_in_data   (req_data),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_out_data  (res_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 0;
    end

    // Score every beat that crosses a channel
    always @(posedge clk) begin
        if (rst_n && req_valid && req_ready)
            sb.take_request(req_data);
        if (rst_n && res_valid && res_ready)
            sb.check_result(res_data);
        if (rst_n && cfg_valid && cfg_ready)
            sb.set_register(cfg_index, cfg_data);
    end

    // Stop a run in which nothing moves any more
    always @(posedge clk) begin
        if ((req_valid && req_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random stalls, or one long hold-off on request
    initial begin : result_sink
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                res_ready <= 1'b0;
                hold_off_req = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end else begin
                res_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [31:0] pick_word();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) begin
            case ($urandom_range(3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'h0;
                default: return 32'hffff_ffff;
            endcase
        end
        if (r < 50)
            return 32'($urandom_range(131072)) - 32'd65536;
        if (r < 70)
            return 32'($urandom_range(33554432)) - 32'd16777216;
        return $urandom();
    endfunction

    // Mostly rows that are fully loaded; otherwise filler or beyond the feature count
    function automatic logic [10:0] pick_index();
        int unsigned r, lim;
        r   = $urandom_range(99);
        lim = (sb.feature_count_q > NUM_FEAT) ? NUM_FEAT : sb.feature_count_q;
        if (r < 75)
            return 11'(full_rows[$urandom_range(full_rows.size() - 1)]);
        if (r < 85)
            return 11'd0;
        return 11'($urandom_range(2047, lim + 1));
    endfunction

    function automatic t_req random_beat(logic [1:0] kind);
        t_req b;
        b.req_type      = kind;
        b.feature_index = 11'($urandom_range(2047));
        b.feature_value = $urandom();
        b.is_last       = 1'($urandom_range(1));
        b.class_index   = 3'($urandom_range(7));
        b.weight_value  = $urandom();
        b.label_value   = $urandom();
        return b;
    endfunction

    function automatic void note_weight(int idx, int cls);
        bit whole;
        if (idx < 1 || idx > NUM_FEAT)
            return;
        wt_seen[cls * NUM_FEAT + idx - 1] = 1'b1;
        whole = 1'b1;
        for (int c = 0; c < NUM_CLS; c++)
            if (!wt_seen[c * NUM_FEAT + idx - 1])
                whole = 1'b0;
        if (whole && !row_listed[idx]) begin
            row_listed[idx] = 1'b1;
            full_rows.push_back(idx);
        end
    endfunction

    // Offer one beat and hold it until taken; then maybe go idle for a while
    task automatic send_beat(input t_req b);
        if (b.req_type != REQ_UNUSED && !(b.req_type == REQ_WEIGHT &&
                (b.feature_index == 0 || b.feature_index > NUM_FEAT)))
            useful_beats++;
        req_valid <= 1'b1;
        req_data  <= b;
        do @(posedge clk); while (!req_ready);
        if ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic send_element(input logic [10:0] idx, input logic [31:0] val,
                                input logic ends_vector);
        t_req b;
        b = random_beat(REQ_FEATURE);
        b.feature_index = idx;
        b.feature_value = val;
        b.is_last       = ends_vector;
        send_beat(b);
    endtask

    task automatic send_weight(input int idx, input int cls, input logic [31:0] val);
        t_req b;
        b = random_beat(REQ_WEIGHT);
        b.feature_index = 11'(idx);
        b.class_index   = 3'(cls);
        b.weight_value  = val;
        note_weight(idx, cls);
        send_beat(b);
    endtask

    task automatic send_label(input int cls, input logic [31:0] val);
        t_req b;
        b = random_beat(REQ_LABEL);
        b.class_index = 3'(cls);
        b.label_value = val;
        send_beat(b);
    endtask

    // A write or an unknown request dropped between elements
    task automatic send_stray();
        int unsigned r, idx;
        r = $urandom_range(5);
        if (r < 3) begin
            case ($urandom_range(7))
                0:       idx = 0;
                1:       idx = $urandom_range(2047, NUM_FEAT + 1);
                2:       idx = full_rows[$urandom_range(full_rows.size() - 1)];
                default: idx = $urandom_range(NUM_FEAT, 1);
            endcase
            send_weight(idx, $urandom_range(NUM_CLS - 1), pick_word());
        end else if (r < 5) begin
            send_label($urandom_range(NUM_CLS - 1), pick_word());
        end else begin
            send_beat(random_beat(REQ_UNUSED));
        end
    endtask

    task automatic run_random(input int n);
        int unsigned goal, pick, len, k, idx;
        goal = useful_beats + n;
        while (useful_beats < goal) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                // load a whole row so that it can be read in any class mode
                idx = $urandom_range(1) ? $urandom_range(16, 1) : $urandom_range(NUM_FEAT, 1);
                for (k = 0; k < NUM_CLS; k++)
                    send_weight(idx, k, pick_word());
            end else if (pick < 14) begin
                send_stray();
            end else begin
                len = ($urandom_range(3) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(9) == 0)
                        send_stray();
                    send_element(pick_index(), pick_word(), k == len - 1);
                end
            end
        end
    endtask

    // Drop valid, wait for every owed result, then let the pipeline empty
    task automatic settle_block();
        req_valid <= 1'b0;
        do @(posedge clk); while (sb.predicted_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_mode(input logic [CFG_DATA_W-1:0] cc,
                                input logic [CFG_DATA_W-1:0] fc);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_CLASS_COUNT;
        cfg_data  <= cc;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_FEATURE_COUNT;
        cfg_data  <= fc;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int ph, c;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load labels and two extreme rows in the reset mode
        for (c = 0; c < NUM_CLS; c++)
            send_label(c, (c == 0) ? 32'h7fff_ffff : (c == 1) ? 32'h8000_0000 : pick_word());
        for (c = 0; c < NUM_CLS; c++)
            send_weight(1, c, 32'h8000_0000);
        for (c = 0; c < NUM_CLS; c++)
            send_weight(NUM_FEAT, c, 32'h7fff_ffff);

        // Filler only: zero score
        send_element(11'd0, pick_word(), 1'b1);
        // Saturate high, then low
        send_element(11'd1, 32'h8000_0000, 1'b0);
        send_element(11'd1, 32'h8000_0000, 1'b0);
        send_element(11'd1, 32'h8000_0000, 1'b1);
        send_element(11'd1024, 32'h8000_0000, 1'b0);
        send_element(11'd1024, 32'h8000_0000, 1'b0);
        send_element(11'd1024, 32'h8000_0000, 1'b1);
        // Writes to bad addresses and an unknown request, all dropped by the block
        send_weight(0, 3, pick_word());
        send_weight(2047, 5, pick_word());
        send_beat(random_beat(REQ_UNUSED));
        // Indices beyond the feature range add nothing
        send_element(11'd1025, 32'h7fff_ffff, 1'b0);
        send_element(11'd2047, 32'h8000_0000, 1'b1);
        // Sign of a single product decides the binary class
        send_element(11'd1, 32'h7fff_ffff, 1'b1);
        send_element(11'd1, 32'hffff_ffff, 1'b1);

        for (ph = 0; ph < PHASES; ph++) begin
            settle_block();
            program_mode(11'(PH_CC[ph]), 11'(PH_FC[ph]));
            send_idle_pct  = PH_SEND_IDLE[ph];
            recv_stall_pct = PH_RECV_STALL[ph];
            // Hold the result side off while one-element vectors keep coming
            if (ph == HOLD_PHASE) begin
                hold_off_req = 1'b1;
                repeat (SQUEEZE_BEATS)
                    send_element(11'(full_rows[$urandom_range(full_rows.size() - 1)]),
                                 pick_word(), 1'b1);
            end
            run_random(RAND_PER_PHASE / 2);
            if (ph == PAUSE_PHASE)
                settle_block();
            run_random(RAND_PER_PHASE - RAND_PER_PHASE / 2);
        end

        settle_block();
        if (sb.mismatch_cnt == 0 && sb.predicted_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/slc_pkg.sv
hw/rtl/slc_front.sv
hw/rtl/slc_queue.sv
hw/rtl/slc_back.sv
hw/rtl/sparse_linear_classifier_core.sv
hw/rtl/slc_checker.sv
test/testbench.sv
